@@ hdl/i2crm_pkg.sv @@
// Types and constants shared by the I2C register master files
`timescale 1ns / 1ps
`default_nettype none
package i2crm_pkg;

	typedef enum logic [1:0] {
		OP_SLOT  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NAK    = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_START  = 4'd1,
		PH_ADDRW  = 4'd2,
		PH_REG    = 4'd3,
		PH_RSTART = 4'd4,
		PH_ADDRR  = 4'd5,
		PH_DATA   = 4'd6,
		PH_RBYTE  = 4'd7,
		PH_STOP   = 4'd8
	} phase_t;

	localparam int unsigned ADDR_W = 7;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		op_t        operation;
		logic [7:0] register_address;
		logic [7:0] write_data;
		logic [7:0] read_length;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       read_last;
		logic       done_res;
		status_t    status;
	} out_item_t;

	typedef struct packed {
		phase_t     phase;
		logic [1:0] slot_step;
		logic [3:0] bit_index;
		logic [7:0] shift_byte;
		logic [7:0] bytes_left;
		logic [7:0] held_register;
		logic [7:0] held_write_byte;
		logic       is_read;
		logic       scl_level;
		logic       sda_level;
		logic       nak_seen;
	} state_t;

endpackage
`default_nettype wire

@@ hdl/i2crm_if.sv @@
// Valid/ready channel interfaces for slot items and slot results
`timescale 1ns / 1ps
`default_nettype none
interface i2crm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] register_address;
	logic [7:0] write_data;
	logic [7:0] read_length;
	logic       sda_in;

	modport source (output valid, operation, register_address, write_data, read_length,
		sda_in, input ready);
	modport sink (input valid, operation, register_address, write_data, read_length,
		sda_in, output ready);
endinterface

interface i2crm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic [7:0] read_byte;
	logic       read_valid;
	logic       read_last;
	logic       done_res;
	logic [1:0] status;

	modport source (output valid, scl_out, sda_out, busy_res, read_byte, read_valid,
		read_last, done_res, status, input ready);
	modport sink (input valid, scl_out, sda_out, busy_res, read_byte, read_valid,
		read_last, done_res, status, output ready);
endinterface
`default_nettype wire

@@ hdl/i2crm_step.sv @@
// Next-state and result logic for one bus half-period slot
`timescale 1ns / 1ps
`default_nettype none
module i2crm_step (
	input  wire i2crm_pkg::state_t              st,
	input  wire i2crm_pkg::in_item_t            item,
	input  wire logic [i2crm_pkg::ADDR_W-1:0]   device_address,
	output i2crm_pkg::state_t                   nst,
	output i2crm_pkg::out_item_t                res
);

	always_comb begin
		logic       rejected;
		logic       done;
		logic       rvalid;
		logic       rlast;
		logic       nak;
		logic [7:0] rbyte;
		logic [7:0] left_dec;
		i2crm_pkg::status_t stat;
		logic       busy;

		nst      = st;
		rejected = 1'b0;
		done     = 1'b0;
		rvalid   = 1'b0;
		rlast    = 1'b0;
		nak      = 1'b0;
		rbyte    = 8'd0;
		left_dec = 8'd0;
		stat     = i2crm_pkg::ST_OK;

		// take a command
		if (item.operation == i2crm_pkg::OP_READ || item.operation == i2crm_pkg::OP_WRITE) begin
			if (st.phase != i2crm_pkg::PH_IDLE ||
			    (item.operation == i2crm_pkg::OP_READ && item.read_length == 8'd0)) begin
				rejected = 1'b1;
			end else begin
				nst.is_read         = (item.operation == i2crm_pkg::OP_READ);
				nst.held_register   = item.register_address;
				nst.held_write_byte = item.write_data;
				nst.bytes_left      = (item.operation == i2crm_pkg::OP_READ) ?
					item.read_length : 8'd0;
				nst.nak_seen        = 1'b0;
				nst.phase           = i2crm_pkg::PH_START;
				nst.slot_step       = 2'd0;
			end
		end

		busy = (nst.phase != i2crm_pkg::PH_IDLE);

		case (nst.phase)
			i2crm_pkg::PH_START, i2crm_pkg::PH_RSTART: begin
				nst.scl_level = 1'b1;
				if (nst.slot_step == 2'd0) begin
					nst.sda_level = 1'b1;
					nst.slot_step = 2'd1;
				end else begin
					nst.sda_level = 1'b0;
					nst.bit_index = 4'd0;
					nst.slot_step = 2'd0;
					if (nst.phase == i2crm_pkg::PH_START) begin
						nst.phase      = i2crm_pkg::PH_ADDRW;
						nst.shift_byte = {device_address, 1'b0};
					end else begin
						nst.phase      = i2crm_pkg::PH_ADDRR;
						nst.shift_byte = {device_address, 1'b1};
					end
				end
			end
			i2crm_pkg::PH_ADDRW, i2crm_pkg::PH_REG, i2crm_pkg::PH_ADDRR,
			i2crm_pkg::PH_DATA: begin
				nst.scl_level = (nst.slot_step == 2'd1);
				if (nst.bit_index < i2crm_pkg::BITS_PER_BYTE) begin
					nst.sda_level = nst.shift_byte[7];
					if (nst.slot_step == 2'd2) begin
						nst.slot_step  = 2'd0;
						nst.shift_byte = {nst.shift_byte[6:0], 1'b0};
						nst.bit_index  = nst.bit_index + 4'd1;
					end else begin
						nst.slot_step = nst.slot_step + 2'd1;
					end
				end else begin
					// acknowledge slots: release SDA, sample in the third slot
					nst.sda_level = 1'b1;
					if (nst.slot_step != 2'd2) begin
						nst.slot_step = nst.slot_step + 2'd1;
					end else if (item.sda_in) begin
						nst.nak_seen  = 1'b1;
						nst.phase     = i2crm_pkg::PH_STOP;
						nst.slot_step = 2'd0;
					end else begin
						nst.slot_step = 2'd0;
						nst.bit_index = 4'd0;
						case (nst.phase)
							i2crm_pkg::PH_ADDRW: begin
								nst.phase      = i2crm_pkg::PH_REG;
								nst.shift_byte = nst.held_register;
							end
							i2crm_pkg::PH_REG: begin
								if (nst.is_read) begin
									nst.phase     = i2crm_pkg::PH_RSTART;
									nst.bit_index = st.bit_index;
								end else begin
									nst.phase      = i2crm_pkg::PH_DATA;
									nst.shift_byte = nst.held_write_byte;
								end
							end
							i2crm_pkg::PH_ADDRR: begin
								nst.phase      = i2crm_pkg::PH_RBYTE;
								nst.shift_byte = 8'd0;
							end
							default: begin
								nst.phase     = i2crm_pkg::PH_STOP;
								nst.bit_index = st.bit_index;
							end
						endcase
					end
				end
			end
			i2crm_pkg::PH_RBYTE: begin
				if (nst.bit_index < i2crm_pkg::BITS_PER_BYTE) begin
					if (nst.slot_step == 2'd0 && nst.bit_index != 4'd0)
						nst.shift_byte = {nst.shift_byte[6:0], item.sda_in};
					nst.sda_level = 1'b1;
					nst.scl_level = (nst.slot_step == 2'd1);
					if (nst.slot_step == 2'd1) begin
						nst.slot_step = 2'd0;
						nst.bit_index = nst.bit_index + 4'd1;
					end else begin
						nst.slot_step = nst.slot_step + 2'd1;
					end
				end else begin
					nak = (nst.bytes_left <= 8'd1);
					if (nst.slot_step == 2'd0) begin
						nst.shift_byte = {nst.shift_byte[6:0], item.sda_in};
						rvalid = 1'b1;
						rbyte  = nst.shift_byte;
						rlast  = nak;
					end
					if (nst.slot_step != 2'd3) begin
						nst.sda_level = nak;
						nst.scl_level = (nst.slot_step == 2'd1);
						nst.slot_step = nst.slot_step + 2'd1;
					end else begin
						// release slot after the master acknowledge
						nst.sda_level = 1'b1;
						nst.scl_level = 1'b0;
						left_dec = (nst.bytes_left != 8'd0) ? nst.bytes_left - 8'd1 : 8'd0;
						nst.bytes_left = left_dec;
						nst.slot_step  = 2'd0;
						if (left_dec == 8'd0) begin
							nst.phase = i2crm_pkg::PH_STOP;
						end else begin
							nst.shift_byte = 8'd0;
							nst.bit_index  = 4'd0;
						end
					end
				end
			end
			i2crm_pkg::PH_STOP: begin
				if (nst.slot_step == 2'd0) begin
					nst.scl_level = 1'b0;
					nst.sda_level = 1'b0;
					nst.slot_step = 2'd1;
				end else if (nst.slot_step == 2'd1) begin
					nst.scl_level = 1'b1;
					nst.sda_level = 1'b0;
					nst.slot_step = 2'd2;
				end else begin
					nst.scl_level = 1'b1;
					nst.sda_level = 1'b1;
					done          = 1'b1;
					stat          = nst.nak_seen ? i2crm_pkg::ST_NAK : i2crm_pkg::ST_OK;
					nst.phase     = i2crm_pkg::PH_IDLE;
					nst.slot_step = 2'd0;
					nst.bit_index = 4'd0;
				end
			end
			default: begin
				nst.phase     = i2crm_pkg::PH_IDLE;
				nst.scl_level = 1'b1;
				nst.sda_level = 1'b1;
			end
		endcase

		if (!done && rejected) begin
			done = 1'b1;
			stat = i2crm_pkg::ST_REJECT;
		end

		res.scl_out    = nst.scl_level;
		res.sda_out    = nst.sda_level;
		res.busy_res   = busy;
		res.read_byte  = rvalid ? rbyte : 8'd0;
		res.read_valid = rvalid;
		res.read_last  = rvalid & rlast;
		res.done_res   = done;
		res.status     = done ? stat : i2crm_pkg::ST_OK;
	end

endmodule
`default_nettype wire

@@ hdl/i2c_register_master_core.sv @@
// Top level of the I2C register master: slot register, state, result register
`timescale 1ns / 1ps
`default_nettype none
// Each transaction on req is one bus half-period slot, normally paced by a prescaler, and
// gives exactly one result on rsp with the SCL/SDA levels to drive for that slot (1 is
// released, 0 is pulled low). One slot is taken every clock cycle unless req.ready is low;
// its result is presented on rsp once the slot register has fed the step logic and the
// result register has been loaded.
// The result register is the only stall point: req.ready falls only while a result is held
// unread and a slot already waits behind it. A command (operation 1 or 2) is taken only
// when no transaction is in progress; otherwise, or for a read of zero bytes, the bus is
// left alone and it is answered with done and status 2 (in the final STOP slot, with that
// slot's own status instead). Write device_address only while idle.
module i2c_register_master_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [i2crm_pkg::ADDR_W-1:0]    cfg_wdata,
	i2crm_in_if.sink                             req,
	i2crm_out_if.source                          rsp
);

	logic                          valid_s1;
	i2crm_pkg::in_item_t           item_s1;
	logic                          rsp_valid_q;
	i2crm_pkg::out_item_t          rsp_q;
	logic [i2crm_pkg::ADDR_W-1:0]  tgt_addr_q;
	i2crm_pkg::state_t             state_q;
	i2crm_pkg::state_t             state_nxt;
	i2crm_pkg::out_item_t          res_nxt;
	logic                          advance;
	logic                          req_take;

	assign advance   = valid_s1 & (~rsp_valid_q | rsp.ready);
	assign req.ready = ~valid_s1 | advance;
	assign req_take  = req.valid & req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_addr_q <= '0;
		end else if (cfg_we) begin
			tgt_addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			item_s1.operation        <= i2crm_pkg::op_t'(req.operation);
			item_s1.register_address <= req.register_address;
			item_s1.write_data       <= req.write_data;
			item_s1.read_length      <= req.read_length;
			item_s1.sda_in           <= req.sda_in;
		end
	end

	i2crm_step u_step (
		.st             (state_q),
		.item           (item_s1),
		.device_address (tgt_addr_q),
		.nst            (state_nxt),
		.res            (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase           <= i2crm_pkg::PH_IDLE;
			state_q.slot_step       <= '0;
			state_q.bit_index       <= '0;
			state_q.shift_byte      <= '0;
			state_q.bytes_left      <= '0;
			state_q.held_register   <= '0;
			state_q.held_write_byte <= '0;
			state_q.is_read         <= 1'b0;
			state_q.scl_level       <= 1'b1;
			state_q.sda_level       <= 1'b1;
			state_q.nak_seen        <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= res_nxt;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.scl_out    = rsp_q.scl_out;
	assign rsp.sda_out    = rsp_q.sda_out;
	assign rsp.busy_res   = rsp_q.busy_res;
	assign rsp.read_byte  = rsp_q.read_byte;
	assign rsp.read_valid = rsp_q.read_valid;
	assign rsp.read_last  = rsp_q.read_last;
	assign rsp.done_res   = rsp_q.done_res;
	assign rsp.status     = rsp_q.status;

endmodule
`default_nettype wire

@@ hdl/i2crm_checker.sv @@
// Port-level checks on the I2C register master and their bind
`timescale 1ns / 1ps
`default_nettype none
module i2crm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic       scl_out,
	input wire logic       sda_out,
	input wire logic       busy_res,
	input wire logic       read_valid,
	input wire logic       read_last,
	input wire logic [7:0] read_byte,
	input wire logic       done_res,
	input wire logic [1:0] status
);

	// a byte only completes inside a transaction, with SCL low
	a_read_in_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && read_valid |-> busy_res && !scl_out)
		else $error("read byte outside a transaction");

	// a finished transaction ends on its STOP slot with both lines released
	a_finish_stop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && done_res && status != i2crm_pkg::ST_REJECT |->
			busy_res && scl_out && sda_out && !read_valid)
		else $error("transaction finished without a STOP slot");

	// side fields stay zero when their flag is clear
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (done_res || status == 2'd0) &&
			(read_valid || (read_byte == 8'd0 && !read_last)))
		else $error("result field set without its flag");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn while stalled");

endmodule

bind i2c_register_master_core i2crm_checker u_i2crm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.scl_out    (rsp.scl_out),
	.sda_out    (rsp.sda_out),
	.busy_res   (rsp.busy_res),
	.read_valid (rsp.read_valid),
	.read_last  (rsp.read_last),
	.read_byte  (rsp.read_byte),
	.done_res   (rsp.done_res),
	.status     (rsp.status)
);
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the I2C register master core: slot stimulus and result checks
`timescale 1ns / 1ps
module tb_top;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;
	localparam int ITEM_BUDGET = 400;

	typedef enum {DATA_RANDOM, DATA_ONES, DATA_ZEROS} data_mode_t;

	// Bus-level model of the master: one slot in, one expected slot result out
	class i2c_bus_model;
		logic [6:0]                 target_addr;
		i2crm_pkg::phase_t          phase;
		logic [1:0]                 slot_step;
		logic [3:0]                 bit_index;
		logic [7:0]                 shift_byte;
		logic [7:0]                 bytes_left;
		logic [7:0]                 held_reg;
		logic [7:0]                 held_wbyte;
		logic                       is_read;
		logic                       scl_lvl;
		logic                       sda_lvl;
		logic                       nak_seen;
		i2crm_pkg::out_item_t       expected_slots[$];
		int mismatches, checked, n_ok, n_nak, n_reject, n_bytes;

		function new();
			target_addr = '0;
			phase = i2crm_pkg::PH_IDLE;
			slot_step = '0;
			bit_index = '0;
			shift_byte = '0;
			bytes_left = '0;
			held_reg = '0;
			held_wbyte = '0;
			is_read = 1'b0;
			scl_lvl = 1'b1;
			sda_lvl = 1'b1;
			nak_seen = 1'b0;
		endfunction

		function void load_byte(i2crm_pkg::phase_t ph, logic [7:0] value);
			phase = ph;
			shift_byte = value;
			bit_index = '0;
			slot_step = '0;
		endfunction

		function void to_stop();
			phase = i2crm_pkg::PH_STOP;
			slot_step = '0;
		endfunction

		// One slot of a sent byte or of the ACK that follows it
		function void send_bit_slot(logic sda_bit);
			if (bit_index < i2crm_pkg::BITS_PER_BYTE) begin
				sda_lvl = shift_byte[7];
				scl_lvl = (slot_step == 2'd1);
				slot_step++;
				if (slot_step >= 2'd3) begin
					slot_step = '0;
					shift_byte = shift_byte << 1;
					bit_index++;
				end
			end else begin
				sda_lvl = 1'b1;
				scl_lvl = (slot_step == 2'd1);
				if (slot_step < 2'd2)
					slot_step++;
				else if (sda_bit) begin
					nak_seen = 1'b1;
					to_stop();
				end else begin
					case (phase)
						i2crm_pkg::PH_ADDRW: load_byte(i2crm_pkg::PH_REG, held_reg);
						i2crm_pkg::PH_REG: begin
							if (is_read) begin
								phase = i2crm_pkg::PH_RSTART;
								slot_step = '0;
							end else
								load_byte(i2crm_pkg::PH_DATA, held_wbyte);
						end
						i2crm_pkg::PH_ADDRR: load_byte(i2crm_pkg::PH_RBYTE, 8'h00);
						default: to_stop();
					endcase
				end
			end
		endfunction

		function void take_slot(logic [1:0] op, logic [7:0] reg_num, logic [7:0] wbyte,
				logic [7:0] rlen, logic sda_bit);
			i2crm_pkg::out_item_t e;
			logic      rejected;
			logic      nak;
			e = '0;
			rejected = 1'b0;
			if (op == i2crm_pkg::OP_READ || op == i2crm_pkg::OP_WRITE) begin
				if (phase != i2crm_pkg::PH_IDLE || (op == i2crm_pkg::OP_READ && rlen == 8'd0))
					rejected = 1'b1;
				else begin
					is_read = (op == i2crm_pkg::OP_READ);
					held_reg = reg_num;
					held_wbyte = wbyte;
					bytes_left = (op == i2crm_pkg::OP_READ) ? rlen : 8'd0;
					nak_seen = 1'b0;
					phase = i2crm_pkg::PH_START;
					slot_step = '0;
				end
			end
			e.busy_res = (phase != i2crm_pkg::PH_IDLE);
			case (phase)
				i2crm_pkg::PH_START, i2crm_pkg::PH_RSTART: begin
					scl_lvl = 1'b1;
					if (slot_step == 2'd0) begin
						sda_lvl = 1'b1;
						slot_step = 2'd1;
					end else begin
						sda_lvl = 1'b0;
						if (phase == i2crm_pkg::PH_START)
							load_byte(i2crm_pkg::PH_ADDRW, {target_addr, 1'b0});
						else
							load_byte(i2crm_pkg::PH_ADDRR, {target_addr, 1'b1});
					end
				end
				i2crm_pkg::PH_ADDRW, i2crm_pkg::PH_REG, i2crm_pkg::PH_ADDRR,
				i2crm_pkg::PH_DATA: send_bit_slot(sda_bit);
				i2crm_pkg::PH_RBYTE: begin
					if (bit_index < i2crm_pkg::BITS_PER_BYTE) begin
						// the previous bit was sampled at the end of the last high slot
						if (slot_step == 2'd0 && bit_index > 0)
							shift_byte = {shift_byte[6:0], sda_bit};
						sda_lvl = 1'b1;
						scl_lvl = (slot_step == 2'd1);
						slot_step++;
						if (slot_step >= 2'd2) begin
							slot_step = '0;
							bit_index++;
						end
					end else begin
						nak = (bytes_left <= 8'd1);
						if (slot_step == 2'd0) begin
							shift_byte = {shift_byte[6:0], sda_bit};
							e.read_valid = 1'b1;
							e.read_byte = shift_byte;
							e.read_last = nak;
							n_bytes++;
						end
						if (slot_step < 2'd3) begin
							sda_lvl = nak;
							scl_lvl = (slot_step == 2'd1);
							slot_step++;
						end else begin
							sda_lvl = 1'b1;
							scl_lvl = 1'b0;
							if (bytes_left > 0)
								bytes_left--;
							if (bytes_left == 0)
								to_stop();
							else
								load_byte(i2crm_pkg::PH_RBYTE, 8'h00);
						end
					end
				end
				i2crm_pkg::PH_STOP: begin
					if (slot_step == 2'd0) begin
						scl_lvl = 1'b0;
						sda_lvl = 1'b0;
						slot_step = 2'd1;
					end else if (slot_step == 2'd1) begin
						scl_lvl = 1'b1;
						sda_lvl = 1'b0;
						slot_step = 2'd2;
					end else begin
						scl_lvl = 1'b1;
						sda_lvl = 1'b1;
						e.done_res = 1'b1;
						e.status = nak_seen ? i2crm_pkg::ST_NAK : i2crm_pkg::ST_OK;
						if (nak_seen)
							n_nak++;
						else
							n_ok++;
						phase = i2crm_pkg::PH_IDLE;
						slot_step = '0;
						bit_index = '0;
					end
				end
				default: begin
					scl_lvl = 1'b1;
					sda_lvl = 1'b1;
				end
			endcase
			// a command dropped in the final STOP slot reports the finishing transaction
			if (!e.done_res && rejected) begin
				e.done_res = 1'b1;
				e.status = i2crm_pkg::ST_REJECT;
				n_reject++;
			end
			e.scl_out = scl_lvl;
			e.sda_out = sda_lvl;
			expected_slots.push_back(e);
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void match_slot(i2crm_pkg::out_item_t got);
			i2crm_pkg::out_item_t want;
			if (expected_slots.size() == 0) begin
				$display("%0t: unexpected slot result, expected none actual %h", $time, got);
				mismatches++;
				return;
			end
			want = expected_slots.pop_front();
			checked++;
			check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
			check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
			check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
			check_field("read_byte", want.read_byte, got.read_byte);
			check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
			check_field("read_last", 8'(want.read_last), 8'(got.read_last));
			check_field("done_res", 8'(want.done_res), 8'(got.done_res));
			check_field("status", 8'(want.status), 8'(got.status));
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [i2crm_pkg::ADDR_W-1:0] cfg_wdata;

	i2crm_in_if  req_if();
	i2crm_out_if rsp_if();

	i2c_register_master_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	i2c_bus_model bus = new();

	int burst_left;
	int n_slots;
	int quiet_cycles;
	int stall_mode;
	int stall_left;
	int rx_cycle;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: check each transaction, then pick the next ready level
	always @(posedge clk) begin
		i2crm_pkg::out_item_t got;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				got.scl_out = rsp_if.scl_out;
				got.sda_out = rsp_if.sda_out;
				got.busy_res = rsp_if.busy_res;
				got.read_byte = rsp_if.read_byte;
				got.read_valid = rsp_if.read_valid;
				got.read_last = rsp_if.read_last;
				got.done_res = rsp_if.done_res;
				got.status = i2crm_pkg::status_t'(rsp_if.status);
				bus.match_slot(got);
			end
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(4, 80);
			end else
				stall_left--;
			rx_cycle++;
			case (stall_mode)
				0: rsp_if.ready <= 1'b1;
				1: rsp_if.ready <= ($urandom_range(0, 99) < 70);
				2: rsp_if.ready <= ($urandom_range(0, 99) < 25);
				default: rsp_if.ready <= (rx_cycle % 5 != 4);
			endcase
		end
	end

	// Abort if neither side moves a transaction for too long
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offer one slot, with a random gap at the start of each burst; return on acceptance
	task automatic push_slot(input logic [1:0] op, input logic [7:0] reg_num,
			input logic [7:0] wbyte, input logic [7:0] rlen, input logic sda_bit);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			gap = $urandom_range(0, 10);
			repeat (gap) begin
				req_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_if.valid <= 1'b1;
		req_if.operation <= op;
		req_if.register_address <= reg_num;
		req_if.write_data <= wbyte;
		req_if.read_length <= rlen;
		req_if.sda_in <= sda_bit;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		bus.take_slot(op, reg_num, wbyte, rlen, sda_bit);
		burst_left--;
		n_slots++;
	endtask

	task automatic idle_slots(input int count);
		repeat (count)
			push_slot(($urandom_range(0, 3) == 0) ? OP_UNUSED : i2crm_pkg::OP_SLOT,
				8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	// Issue one command and play the target until the bus is idle again.
	// nak_ack picks which target ACK is answered with NAK (0 for none).
	task automatic run_command(input logic [1:0] op, input logic [7:0] reg_num,
			input logic [7:0] wbyte, input logic [7:0] rlen, input int nak_ack,
			input data_mode_t data_mode, input int jam_slot, input bit jam_stop);
		int ack_no;
		int slot_no;
		logic [1:0] slot_op;
		logic sda;
		ack_no = 0;
		slot_no = 0;
		push_slot(op, reg_num, wbyte, rlen, 1'($urandom_range(0, 1)));
		while (bus.phase != i2crm_pkg::PH_IDLE) begin
			slot_no++;
			slot_op = ($urandom_range(0, 9) == 0) ? OP_UNUSED : i2crm_pkg::OP_SLOT;
			sda = 1'($urandom_range(0, 1));
			if (bus.phase inside {i2crm_pkg::PH_ADDRW, i2crm_pkg::PH_REG, i2crm_pkg::PH_ADDRR,
					i2crm_pkg::PH_DATA}
					&& bus.bit_index == i2crm_pkg::BITS_PER_BYTE && bus.slot_step == 2'd2) begin
				ack_no++;
				sda = (ack_no == nak_ack);
			end else if (bus.phase == i2crm_pkg::PH_RBYTE) begin
				if (data_mode == DATA_ONES)
					sda = 1'b1;
				else if (data_mode == DATA_ZEROS)
					sda = 1'b0;
			end
			// commands while busy are refused; in the final STOP slot they are dropped
			if (slot_no == jam_slot
					|| (jam_stop && bus.phase == i2crm_pkg::PH_STOP && bus.slot_step == 2'd2))
				slot_op = ($urandom_range(0, 1) == 0) ? i2crm_pkg::OP_READ : i2crm_pkg::OP_WRITE;
			push_slot(slot_op, 8'($urandom), 8'($urandom), 8'($urandom), sda);
		end
	endtask

	task automatic random_command();
		int pick;
		int r;
		logic [7:0] rlen;
		int nak_ack;
		data_mode_t mode;
		pick = $urandom_range(0, 99);
		// keep reads short so the run stays near its item budget
		rlen = 8'($urandom_range(1, 3));
		nak_ack = ($urandom_range(0, 99) < 12) ? $urandom_range(1, 4) : 0;
		r = $urandom_range(0, 9);
		mode = (r == 0) ? DATA_ONES : (r == 1) ? DATA_ZEROS : DATA_RANDOM;
		if (pick < 45)
			run_command(i2crm_pkg::OP_READ, 8'($urandom), 8'($urandom), rlen, nak_ack, mode,
				($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : 0,
				$urandom_range(0, 99) < 15);
		else if (pick < 80)
			run_command(i2crm_pkg::OP_WRITE, 8'($urandom), 8'($urandom), 8'($urandom),
				nak_ack, mode, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : 0,
				$urandom_range(0, 99) < 15);
		else if (pick < 87)
			run_command(i2crm_pkg::OP_READ, 8'($urandom), 8'($urandom), 8'd0, 0,
				DATA_RANDOM, 0, 1'b0);
		else if (pick < 92)
			run_command(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 0, DATA_RANDOM,
				0, 1'b0);
		else
			idle_slots($urandom_range(1, 6));
		if ($urandom_range(0, 9) < 3)
			idle_slots($urandom_range(1, 5));
	endtask

	// Hold the request side until every result is in, then write the address
	task automatic set_address(input logic [6:0] addr);
		req_if.valid <= 1'b0;
		while (bus.expected_slots.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= addr;
		@(posedge clk);
		cfg_we <= 1'b0;
		bus.target_addr = addr;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.operation = i2crm_pkg::OP_SLOT;
		req_if.register_address = '0;
		req_if.write_data = '0;
		req_if.read_length = '0;
		req_if.sda_in = 1'b1;
		rsp_if.ready = 1'b0;
		burst_left = 0;
		stall_left = 0;
		stall_mode = 0;
		rx_cycle = 0;
		quiet_cycles = 0;
		n_slots = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, a NAK abort, refused and dropped commands
		set_address(7'h7F);
		run_command(i2crm_pkg::OP_READ, 8'h5A, 8'hA5, 8'd0, 0, DATA_RANDOM, 0, 1'b0);
		run_command(OP_UNUSED, 8'h12, 8'h34, 8'd5, 0, DATA_RANDOM, 0, 1'b0);
		run_command(i2crm_pkg::OP_WRITE, 8'h11, 8'h22, 8'd0, 1, DATA_RANDOM, 5, 1'b1);
		run_command(i2crm_pkg::OP_READ, 8'hFF, 8'hFF, 8'd2, 0, DATA_ONES, 20, 1'b1);
		set_address(7'h00);
		run_command(i2crm_pkg::OP_WRITE, 8'h00, 8'hFF, 8'd255, 0, DATA_RANDOM, 0, 1'b0);

		// random: well-formed transactions with random content and occasional faults
		set_address(7'($urandom_range(0, 127)));
		while (n_slots < ITEM_BUDGET - 80)
			random_command();

		req_if.valid <= 1'b0;
		while (bus.expected_slots.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d slots sent, %0d results checked, %0d bytes read", n_slots, bus.checked,
			bus.n_bytes);
		$display("transactions: %0d completed, %0d ended on NAK, %0d commands refused",
			bus.n_ok, bus.n_nak, bus.n_reject);
		if (bus.mismatches == 0 && bus.expected_slots.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
